/* src/psbfa_pkg.sv */
// package: constants and types for the page span allocator
`timescale 1ns / 1ps
package psbfa_pkg;
  localparam int unsigned BinCount   = 8193;
  localparam int unsigned ChunkPages = 8192;
  localparam int unsigned MaxChunks  = 4;
  localparam int unsigned WordBits   = 64;
  localparam int unsigned OccWords   = (BinCount + WordBits - 1) / WordBits;
  localparam int unsigned BinW       = $clog2(BinCount);
  localparam int unsigned WordIdxW   = $clog2(OccWords);
  localparam int unsigned BitIdxW    = $clog2(WordBits);
  localparam int unsigned BaseW      = 15;
  localparam int unsigned PagesW     = 20;
  localparam int unsigned ChunkCntW  = 3;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusTooBig  = 2'd1;
  localparam logic [1:0] StatusNoChunk = 2'd2;

  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  typedef logic [WordBits-1:0] occ_word_t;

  // lowest set bit of a word, valid flag separately
  function automatic logic [BitIdxW-1:0] lowest_bit(input occ_word_t w);
    logic [BitIdxW-1:0] r;
    r = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (w[i]) r = BitIdxW'(i);
    end
    return r;
  endfunction
endpackage

/* src/psbfa_occ_scan.sv */
// bin occupancy bitmap in a word memory with a summary vector and word scan
`timescale 1ns / 1ps
module psbfa_occ_scan import psbfa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                find_i,
  input  logic [BinW-1:0]     need_i,
  output logic                found_o,
  output logic [BinW-1:0]     fit_o,
  input  logic                set_i,
  input  logic                clr_i,
  input  logic [BinW-1:0]     bin_i,
  output logic                bit_o
);
  occ_word_t              occ_mem [OccWords];
  occ_word_t              rd_a_q, rd_b_q;
  logic [OccWords-1:0]    sum_q;
  logic [WordIdxW-1:0]    w_first, w_next, w_bin, addr_a;
  logic [WordIdxW-1:0]    w_first_q, w_next_q;
  logic [BitIdxW-1:0]     b_first, b_bin, b_first_q;
  logic                   first_ok_q, has_next_q;
  occ_word_t              cur_word, new_word, first_word, next_word;
  logic [OccWords-1:0]    above;
  logic                   has_next;

  assign w_first = need_i[BinW-1:BitIdxW];
  assign b_first = need_i[BitIdxW-1:0];
  assign w_bin   = bin_i[BinW-1:BitIdxW];
  assign b_bin   = bin_i[BitIdxW-1:0];
  assign addr_a  = find_i ? w_first : w_bin;

  always_comb begin
    above = '0;
    for (int i = 0; i < OccWords; i++) begin
      above[i] = sum_q[i] && (WordIdxW'(i) > w_first);
    end
    has_next = |above;
    w_next = '0;
    for (int i = OccWords - 1; i >= 0; i--) begin
      if (above[i]) w_next = WordIdxW'(i);
    end
  end

  // an empty word reads as zero whatever the memory holds
  assign cur_word = sum_q[w_bin] ? rd_a_q : '0;
  assign bit_o    = cur_word[b_bin];

  always_comb begin
    new_word        = cur_word;
    new_word[b_bin] = set_i;
  end

  assign first_word = (first_ok_q ? rd_a_q : '0) & ({WordBits{1'b1}} << b_first_q);
  assign next_word  = has_next_q ? rd_b_q : '0;
  assign found_o    = (first_word != '0) || has_next_q;
  assign fit_o      = (first_word != '0) ? {w_first_q, lowest_bit(first_word)}
                                         : {w_next_q, lowest_bit(next_word)};

  always_ff @(posedge clk_i) begin
    if (set_i || clr_i) occ_mem[w_bin] <= new_word;
    rd_a_q <= occ_mem[addr_a];
    rd_b_q <= occ_mem[w_next];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      w_first_q  <= '0;
      w_next_q   <= '0;
      b_first_q  <= '0;
      first_ok_q <= 1'b0;
      has_next_q <= 1'b0;
    end else begin
      if (set_i || clr_i) sum_q[w_bin] <= |new_word;
      if (find_i) begin
        w_first_q  <= w_first;
        b_first_q  <= b_first;
        first_ok_q <= sum_q[w_first];
        w_next_q   <= w_next;
        has_next_q <= has_next;
      end
    end
  end
endmodule

/* src/psbfa_ram.sv */
// generic single port ram with registered read
`timescale 1ns / 1ps
module psbfa_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

/* src/page_span_best_fit_allocator.sv */
// top level: page span allocator with binned free stacks
// done_o the cycle after accept for zero or oversize; allocs go S_FIND, S_DEC, then
// S_DONE if failed or a whole chunk; a free or chunk open pushes via S_PTOP, S_PLNK,
// S_PWR; a pop via S_PTOP, S_PUT, S_PUL; a split pop pops then pushes the remainder
// one request at a time on single port bin-top and link rams, next accept after done_o
// reset: bitmap summary and chunk count cleared at once, memories left unwritten
// results show for one cycle on done_o; the receiver cannot stall
`timescale 1ns / 1ps
module page_span_best_fit_allocator import psbfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              req_type_i,
  input  logic [PagesW-1:0] pages_i,
  input  logic [BaseW-1:0]  free_base_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_wdata_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [BaseW-1:0]  base_page_o,
  output logic              opened_chunk_o
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_FIND = 9'b000000010, S_DEC  = 9'b000000100,
    S_PTOP = 9'b000001000, S_PLNK = 9'b000010000, S_PWR  = 9'b000100000,
    S_PUT  = 9'b001000000, S_PUL  = 9'b010000000, S_DONE = 9'b100000000
  } state_e;

  state_e               state_q, state_d;
  logic [2:0]           limit_q;
  logic [ChunkCntW-1:0] chunks_q;
  logic [BinW-1:0]      need_q, pbin_q;
  logic [BaseW-1:0]     pbase_q, base_q;
  logic [1:0]           stat_q;
  logic                 opened_q, popping_q;
  logic                 find, found, occ_set, occ_clr;
  logic [BinW-1:0]      fit, occ_bin;
  logic                 top_we, lnk_we;
  logic [BinW-1:0]      top_addr;
  logic [BaseW-1:0]     top_wd, top_rd, lnk_addr;
  logic [BaseW:0]       lnk_wd, lnk_rd;
  logic                 pbusy;
  logic [2:0]           lim;

  assign lim = (limit_q < 3'(MaxChunks)) ? limit_q : 3'(MaxChunks);

  psbfa_occ_scan u_occ (
    .clk_i, .rst_ni, .find_i(find), .need_i(need_q), .found_o(found),
    .fit_o(fit), .set_i(occ_set), .clr_i(occ_clr), .bin_i(occ_bin), .bit_o(pbusy)
  );
  psbfa_ram #(.Depth(BinCount), .Width(BaseW)) u_top (
    .clk_i, .we_i(top_we), .addr_i(top_addr), .wdata_i(top_wd), .rdata_o(top_rd)
  );
  psbfa_ram #(.Depth(32768), .Width(BaseW + 1)) u_lnk (
    .clk_i, .we_i(lnk_we), .addr_i(lnk_addr), .wdata_i(lnk_wd), .rdata_o(lnk_rd)
  );

  // bitmap word of the pushed or popped bin is read in S_PTOP and held after
  assign find = (state_q == S_FIND);

  always_comb begin
    state_d  = state_q;
    top_we   = 1'b0;
    top_addr = pbin_q;
    top_wd   = pbase_q;
    lnk_we   = 1'b0;
    lnk_addr = pbase_q;
    lnk_wd   = '0;
    occ_set  = 1'b0;
    occ_clr  = 1'b0;
    occ_bin  = pbin_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (pages_i == '0 || pages_i >= PagesW'(BinCount)) state_d = S_DONE;
          else if (req_type_i == ReqFree) state_d = S_PTOP;
          else state_d = S_FIND;
        end
      end
      S_FIND: state_d = S_DEC;
      S_DEC: begin
        if (chunks_q != '0 && found) state_d = S_PTOP;
        else if (need_q > BinW'(ChunkPages) || chunks_q >= lim ||
                 need_q == BinW'(ChunkPages)) state_d = S_DONE;
        else state_d = S_PTOP;
      end
      S_PTOP: state_d = popping_q ? S_PUT : S_PLNK;
      S_PLNK: state_d = S_PWR;
      S_PWR: begin
        lnk_we  = 1'b1;
        lnk_wd  = pbusy ? {1'b1, top_rd} : '0;
        top_we  = 1'b1;
        occ_set = 1'b1;
        state_d = S_DONE;
      end
      S_PUT: begin
        lnk_addr = top_rd;
        state_d  = S_PUL;
      end
      S_PUL: begin
        top_we  = lnk_rd[BaseW];
        top_wd  = lnk_rd[BaseW-1:0];
        occ_clr = !lnk_rd[BaseW];
        state_d = (pbin_q > need_q) ? S_PTOP : S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      limit_q   <= 3'd4;
      chunks_q  <= '0;
      need_q    <= '0;
      pbin_q    <= '0;
      pbase_q   <= '0;
      base_q    <= '0;
      stat_q    <= StatusOk;
      opened_q  <= 1'b0;
      popping_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            need_q    <= BinW'(pages_i);
            base_q    <= '0;
            stat_q    <= (pages_i >= PagesW'(BinCount)) ? StatusTooBig : StatusOk;
            opened_q  <= 1'b0;
            popping_q <= 1'b0;
            pbin_q    <= BinW'(pages_i);
            pbase_q   <= free_base_i;
          end
        end
        S_DEC: begin
          if (chunks_q != '0 && found) begin
            pbin_q    <= fit;
            popping_q <= 1'b1;
          end else if (need_q > BinW'(ChunkPages)) stat_q <= StatusTooBig;
          else if (chunks_q >= lim) stat_q <= StatusNoChunk;
          else begin
            base_q   <= BaseW'(32'(chunks_q) * ChunkPages);
            chunks_q <= chunks_q + 1'b1;
            opened_q <= 1'b1;
            if (need_q != BinW'(ChunkPages)) begin
              pbin_q  <= BinW'(ChunkPages) - need_q;
              pbase_q <= BaseW'(32'(chunks_q) * ChunkPages + 32'(need_q));
            end
          end
        end
        S_PUL: begin
          base_q <= top_rd;
          if (pbin_q > need_q) begin
            popping_q <= 1'b0;
            pbin_q    <= pbin_q - need_q;
            pbase_q   <= top_rd + BaseW'(need_q);
          end
        end
        default: ;
      endcase
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = (state_q == S_DONE);
  assign status_o       = stat_q;
  assign base_page_o    = (stat_q == StatusOk) ? base_q : '0;
  assign opened_chunk_o = opened_q;

  a_chunks_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunks_q <= ChunkCntW'(MaxChunks)) else $error("chunk count overflow");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held two cycles");
  a_opened_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && opened_chunk_o |-> status_o == StatusOk) else $error("bad open");
endmodule
